[rtl/ubxnmea_pkg.sv]
package ubxnmea_pkg;

    // sizing
    localparam int MAX_PAYLOAD   = 128;
    localparam int LINE_CAPACITY = 128;
    localparam int CNT_W         = $clog2(MAX_PAYLOAD + 1);
    localparam int LINE_W        = $clog2(LINE_CAPACITY);
    localparam int LEN_W         = 16;
    localparam int TIME_OFS      = 12;
    localparam int TIME_BYTES    = 8;
    localparam int TIME_IDX_W    = $clog2(TIME_BYTES);
    localparam int TIME_MIN_LEN  = TIME_OFS + TIME_BYTES;
    localparam int VALID_UTC_BIT = 2;

    // byte codes
    localparam logic [7:0] SYNC_1   = 8'hB5;
    localparam logic [7:0] SYNC_2   = 8'h62;
    localparam logic [7:0] ASCII_LF = 8'h0A;
    localparam logic [7:0] ASCII_CR = 8'h0D;
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    // configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_CLASS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_ID       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EARLIEST_YEAR = 2'd2;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]  RST_TIME_CLASS    = 8'h01;
    localparam logic [7:0]  RST_TIME_ID       = 8'h21;
    localparam logic [15:0] RST_EARLIEST_YEAR = 16'd2025;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } t_frame_phase;

    typedef struct packed {
        logic [7:0]  time_class;
        logic [7:0]  time_id;
        logic [15:0] earliest_year;
    } t_cfg;

    typedef struct packed {
        logic        event_kind;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [7:0]  item_length;
        logic        checksum_ok;
        logic        time_accepted;
        logic [15:0] tm_year;
        logic [3:0]  tm_month;
        logic [4:0]  tm_day;
        logic [7:0]  tm_hour;
        logic [7:0]  tm_minute;
        logic [7:0]  tm_second;
    } t_result;

    localparam logic EVT_FRAME = 1'b0;
    localparam logic EVT_LINE  = 1'b1;

endpackage

[rtl/ubxnmea_frame.sv]
module ubxnmea_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_byte,
    input  ubxnmea_pkg::t_cfg   i_cfg,
    output logic                o_busy,
    output logic                o_done,
    output ubxnmea_pkg::t_result o_result
);

    ubxnmea_pkg::t_frame_phase r_phase, n_phase;
    logic [7:0]                          r_class, n_class;
    logic [7:0]                          r_id, n_id;
    logic [ubxnmea_pkg::LEN_W-1:0]       r_len, n_len;
    logic [ubxnmea_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [7:0]                          r_sum_a, n_sum_a;
    logic [7:0]                          r_sum_b, n_sum_b;
    logic [7:0]                          r_ck_a, n_ck_a;
    logic [7:0]                          r_time [ubxnmea_pkg::TIME_BYTES];
    logic [7:0]                          n_time [ubxnmea_pkg::TIME_BYTES];

    logic [7:0]                          add_a, add_b;
    logic [ubxnmea_pkg::CNT_W:0]         cnt_inc;
    logic [ubxnmea_pkg::CNT_W-1:0]       time_off;
    logic [ubxnmea_pkg::LEN_W-1:0]       len_full;
    logic                                in_time_window;
    logic                                ck_ok, time_msg, time_good;
    logic [15:0]                         year;

    // Fletcher-8 step
    assign add_a    = r_sum_a + i_byte;
    assign add_b    = r_sum_b + add_a;
    assign cnt_inc  = {1'b0, r_cnt} + 1'b1;
    assign time_off = r_cnt - ubxnmea_pkg::CNT_W'(ubxnmea_pkg::TIME_OFS);
    assign len_full = {i_byte, r_len[7:0]};
    assign in_time_window = (r_cnt >= ubxnmea_pkg::CNT_W'(ubxnmea_pkg::TIME_OFS))
                         && (r_cnt <  ubxnmea_pkg::CNT_W'(ubxnmea_pkg::TIME_MIN_LEN));

    assign o_busy = (r_phase != ubxnmea_pkg::PH_SYNC1);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_class = r_class;
        n_id    = r_id;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_ck_a  = r_ck_a;
        n_time  = r_time;
        if (i_en) begin
            case (r_phase)
                ubxnmea_pkg::PH_SYNC1: begin
                    if (i_byte == ubxnmea_pkg::SYNC_1) begin
                        n_phase = ubxnmea_pkg::PH_SYNC2;
                    end
                end
                ubxnmea_pkg::PH_SYNC2: begin
                    n_sum_a = '0;
                    n_sum_b = '0;
                    if (i_byte == ubxnmea_pkg::SYNC_2) begin
                        n_phase = ubxnmea_pkg::PH_CLASS;
                    end else begin
                        n_phase = ubxnmea_pkg::PH_SYNC1;
                        n_cnt   = '0;
                        n_len   = '0;
                    end
                end
                ubxnmea_pkg::PH_CLASS: begin
                    n_class = i_byte;
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_phase = ubxnmea_pkg::PH_ID;
                end
                ubxnmea_pkg::PH_ID: begin
                    n_id    = i_byte;
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_phase = ubxnmea_pkg::PH_LEN_LO;
                end
                ubxnmea_pkg::PH_LEN_LO: begin
                    n_len   = {8'h00, i_byte};
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_phase = ubxnmea_pkg::PH_LEN_HI;
                end
                ubxnmea_pkg::PH_LEN_HI: begin
                    n_len   = len_full;
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    if (len_full > ubxnmea_pkg::LEN_W'(ubxnmea_pkg::MAX_PAYLOAD)) begin
                        // oversize frame: dropped without a report
                        n_phase = ubxnmea_pkg::PH_SYNC1;
                        n_cnt   = '0;
                        n_len   = '0;
                        n_sum_a = '0;
                        n_sum_b = '0;
                    end else if (len_full == '0) begin
                        n_phase = ubxnmea_pkg::PH_CK_A;
                    end else begin
                        n_cnt   = '0;
                        n_phase = ubxnmea_pkg::PH_PAYLOAD;
                    end
                end
                ubxnmea_pkg::PH_PAYLOAD: begin
                    if (in_time_window) begin
                        n_time[time_off[ubxnmea_pkg::TIME_IDX_W-1:0]] = i_byte;
                    end
                    n_cnt   = cnt_inc[ubxnmea_pkg::CNT_W-1:0];
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    if (ubxnmea_pkg::LEN_W'(cnt_inc) >= r_len) begin
                        n_phase = ubxnmea_pkg::PH_CK_A;
                    end
                end
                ubxnmea_pkg::PH_CK_A: begin
                    n_ck_a  = i_byte;
                    n_phase = ubxnmea_pkg::PH_CK_B;
                end
                default: begin
                    // second checksum byte and unused codes both close the frame
                    n_phase = ubxnmea_pkg::PH_SYNC1;
                    n_cnt   = '0;
                    n_len   = '0;
                    n_sum_a = '0;
                    n_sum_b = '0;
                end
            endcase
        end
    end

    // report on the second checksum byte
    assign year      = {r_time[1], r_time[0]};
    assign ck_ok     = (r_ck_a == r_sum_a) && (i_byte == r_sum_b);
    assign time_msg  = ck_ok && (r_class == i_cfg.time_class) && (r_id == i_cfg.time_id)
                    && (r_len >= ubxnmea_pkg::LEN_W'(ubxnmea_pkg::TIME_MIN_LEN));
    assign time_good = time_msg && r_time[7][ubxnmea_pkg::VALID_UTC_BIT]
                    && (year >= i_cfg.earliest_year)
                    && (r_time[2] >= 8'd1) && (r_time[2] <= 8'd12)
                    && (r_time[3] >= 8'd1) && (r_time[3] <= 8'd31);

    always_comb begin
        o_done   = i_en && (r_phase == ubxnmea_pkg::PH_CK_B);
        o_result = '0;
        o_result.event_kind    = ubxnmea_pkg::EVT_FRAME;
        o_result.frame_class   = r_class;
        o_result.frame_id      = r_id;
        o_result.item_length   = r_len[7:0];
        o_result.checksum_ok   = ck_ok;
        if (time_good) begin
            o_result.time_accepted = 1'b1;
            o_result.tm_year       = year;
            o_result.tm_month      = r_time[2][3:0];
            o_result.tm_day        = r_time[3][4:0];
            o_result.tm_hour       = r_time[4];
            o_result.tm_minute     = r_time[5];
            o_result.tm_second     = r_time[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ubxnmea_pkg::PH_SYNC1;
            r_class <= '0;
            r_id    <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_ck_a  <= '0;
        end else begin
            r_phase <= n_phase;
            r_class <= n_class;
            r_id    <= n_id;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_ck_a  <= n_ck_a;
        end
    end

    // time bytes: undefined until written
    always_ff @(posedge i_clk) begin
        r_time <= n_time;
    end

endmodule

[rtl/ubxnmea_line.sv]
module ubxnmea_line (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    output logic       o_done,
    output logic [7:0] o_len
);

    logic [ubxnmea_pkg::LINE_W-1:0] r_count, n_count;
    logic [ubxnmea_pkg::LINE_W+7:0] count_ext;
    logic                           is_eol, is_print;

    assign is_eol    = (i_byte == ubxnmea_pkg::ASCII_LF) || (i_byte == ubxnmea_pkg::ASCII_CR);
    assign is_print  = (i_byte >= ubxnmea_pkg::PRINT_LO) && (i_byte <= ubxnmea_pkg::PRINT_HI);
    assign count_ext = {8'h00, r_count};
    assign o_len     = count_ext[7:0];
    assign o_done    = i_en && is_eol && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (i_en) begin
            if (is_eol) begin
                n_count = '0;
            end else if (is_print
                && (r_count < ubxnmea_pkg::LINE_W'(ubxnmea_pkg::LINE_CAPACITY - 1))) begin
                n_count = r_count + 1'b1;
            end else begin
                // overflow or non-printable byte: line discarded
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

[rtl/ubx_nmea_stream_demux_parser.sv]
// Serial stream splitter for a satellite receiver port. Each accepted byte is either part of a
// binary frame (B5 62, class, id, 16-bit little-endian length, payload, two Fletcher-8 bytes)
// or part of an ASCII text line. A frame is reported on its second checksum byte with class,
// id, length and checksum status; when it is the configured time message, checks out and holds
// a plausible date, the UTC fields are filled in as well, otherwise they read zero. Frames
// longer than 128 payload bytes vanish without a report. Text lines are reported on CR or LF
// with their character count; empty lines, over-long lines and lines hit by a control byte
// give no report. One byte is taken every clock cycle, sustained, as long as reports are taken
// when offered; a byte's report passes through the input register, then the result register,
// from which it is presented. A waiting result does not hold up new input until the input
// register is also full. Configuration registers (0 time class, 1 time id, 2 earliest year)
// are written through the plain write port; the user must write them only while the stream
// is idle, since the block itself does not enforce this.
module ubx_nmea_stream_demux_parser (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_wr_en,
    input  logic [ubxnmea_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ubxnmea_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // byte stream in
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [7:0]                             i_rx_byte,
    // reports out
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_event_kind,
    output logic [7:0]                             o_frame_class,
    output logic [7:0]                             o_frame_id,
    output logic [7:0]                             o_item_length,
    output logic                                   o_checksum_ok,
    output logic                                   o_time_accepted,
    output logic [15:0]                            o_tm_year,
    output logic [3:0]                             o_tm_month,
    output logic [4:0]                             o_tm_day,
    output logic [7:0]                             o_tm_hour,
    output logic [7:0]                             o_tm_minute,
    output logic [7:0]                             o_tm_second
);

    // configuration registers
    ubxnmea_pkg::t_cfg    r_cfg;

    // input register
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;

    // result register
    logic                 r_out_valid;
    ubxnmea_pkg::t_result r_out;

    logic                 step;
    logic                 frame_busy, to_frame, to_line;
    logic                 frame_done, line_done;
    logic [7:0]           line_len;
    ubxnmea_pkg::t_result frame_res, line_res;

    // the held byte moves on once the result register is free or being emptied
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    // inside a frame (or on a sync byte) everything goes to the frame parser;
    // the line count is left untouched meanwhile
    assign to_frame = step && (frame_busy || (r_in_byte == ubxnmea_pkg::SYNC_1));
    assign to_line  = step && !to_frame;

    ubxnmea_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (to_frame),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_busy   (frame_busy),
        .o_done   (frame_done),
        .o_result (frame_res)
    );

    ubxnmea_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (to_line),
        .i_byte  (r_in_byte),
        .o_done  (line_done),
        .o_len   (line_len)
    );

    always_comb begin
        line_res             = '0;
        line_res.event_kind  = ubxnmea_pkg::EVT_LINE;
        line_res.item_length = line_len;
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_class    <= ubxnmea_pkg::RST_TIME_CLASS;
            r_cfg.time_id       <= ubxnmea_pkg::RST_TIME_ID;
            r_cfg.earliest_year <= ubxnmea_pkg::RST_EARLIEST_YEAR;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ubxnmea_pkg::CFG_TIME_CLASS:    r_cfg.time_class    <= i_cfg_wdata[7:0];
                ubxnmea_pkg::CFG_TIME_ID:       r_cfg.time_id       <= i_cfg_wdata[7:0];
                ubxnmea_pkg::CFG_EARLIEST_YEAR: r_cfg.earliest_year <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= frame_done || line_done;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && frame_done) begin
            r_out <= frame_res;
        end else if (step && line_done) begin
            r_out <= line_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_kind    = r_out.event_kind;
    assign o_frame_class   = r_out.frame_class;
    assign o_frame_id      = r_out.frame_id;
    assign o_item_length   = r_out.item_length;
    assign o_checksum_ok   = r_out.checksum_ok;
    assign o_time_accepted = r_out.time_accepted;
    assign o_tm_year       = r_out.tm_year;
    assign o_tm_month      = r_out.tm_month;
    assign o_tm_day        = r_out.tm_day;
    assign o_tm_hour       = r_out.tm_hour;
    assign o_tm_minute     = r_out.tm_minute;
    assign o_tm_second     = r_out.tm_second;

`ifndef SYNTHESIS
    // frame and line parsers never finish on the same byte
    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(frame_done && line_done))
        else $error("frame and line report on the same byte");

    // a held byte that cannot move on stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input register lost a stalled byte");

    // an accepted time implies a good checksum on a frame with a sane month and day
    a_time_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_time_accepted) |->
            (o_checksum_ok && (o_event_kind == ubxnmea_pkg::EVT_FRAME)
             && (o_tm_month != 4'd0) && (o_tm_day != 5'd0)))
        else $error("time accepted on a bad report");

    // line reports carry no frame content and a nonzero length
    a_line_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_kind == ubxnmea_pkg::EVT_LINE)) |->
            ((o_frame_class == 8'd0) && !o_checksum_ok && !o_time_accepted
             && (o_item_length != 8'd0)))
        else $error("line report carries frame fields");
`endif

endmodule

[tb/ubx_nmea_report_checker.sv]
module ubx_nmea_report_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [ubxnmea_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ubxnmea_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic [7:0]                             i_rx_byte,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  ubxnmea_pkg::t_result                   i_result,
    output int                                     o_pending,
    output int                                     o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import ubxnmea_pkg::*;

    // parser mirror
    t_cfg                  cfg;
    t_frame_phase          phase;
    logic [7:0]            held_cls;
    logic [7:0]            held_fid;
    logic [LEN_W-1:0]      decl_len;
    logic [7:0]            pay_cnt;
    logic [7:0]            sum_a;
    logic [7:0]            sum_b;
    logic [7:0]            rx_ck_a;
    logic [7:0]            time_field [TIME_BYTES];
    logic [LINE_W-1:0]     line_len;

    t_result               expected_reports [$];
    t_result               want;
    t_result               next_report;
    int                    fail_total = 0;
    int                    pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp_val);
        fail_total++;
        $display("%0d ns: mismatch on %s: got %0h, expected %0h", $time, what, got,
                 exp_val);
    endtask

    function automatic void drop_frame();
        phase    = PH_SYNC1;
        pay_cnt  = '0;
        decl_len = '0;
        sum_a    = '0;
        sum_b    = '0;
    endfunction

    function automatic void fletcher(input logic [7:0] b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endfunction

    function automatic void reset_mirror();
        cfg.time_class    = RST_TIME_CLASS;
        cfg.time_id       = RST_TIME_ID;
        cfg.earliest_year = RST_EARLIEST_YEAR;
        held_cls = '0;
        held_fid = '0;
        rx_ck_a  = '0;
        line_len = '0;
        for (int k = 0; k < TIME_BYTES; k++)
            time_field[k] = '0;
        drop_frame();
    endfunction

    // one byte through the splitter; returns 1 when it yields a report
    function automatic bit parse_byte(input logic [7:0] b, output t_result r);
        logic [15:0] yr;
        logic [7:0]  mon;
        logic [7:0]  dd;
        bit          sum_ok;
        r = '0;
        if (phase == PH_SYNC1 && b != SYNC_1) begin
            if (b == ASCII_LF || b == ASCII_CR) begin
                if (line_len != 0) begin
                    r.event_kind  = EVT_LINE;
                    r.item_length = 8'(line_len);
                    line_len      = '0;
                    return 1'b1;
                end
                return 1'b0;
            end
            if (b >= PRINT_LO && b <= PRINT_HI) begin
                if (int'(line_len) < LINE_CAPACITY - 1)
                    line_len = line_len + 1'b1;
                else
                    line_len = '0;
            end else begin
                line_len = '0;
            end
            return 1'b0;
        end
        case (phase)
            PH_SYNC1: begin
                phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (b == SYNC_2) begin
                    sum_a = '0;
                    sum_b = '0;
                    phase = PH_CLASS;
                end else begin
                    drop_frame();
                end
            end
            PH_CLASS: begin
                held_cls = b;
                fletcher(b);
                phase = PH_ID;
            end
            PH_ID: begin
                held_fid = b;
                fletcher(b);
                phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                decl_len = {8'h00, b};
                fletcher(b);
                phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                decl_len[15:8] = b;
                fletcher(b);
                if (int'(decl_len) > MAX_PAYLOAD) begin
                    drop_frame();
                end else if (decl_len == 0) begin
                    phase = PH_CK_A;
                end else begin
                    pay_cnt = '0;
                    phase   = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (int'(pay_cnt) >= TIME_OFS && int'(pay_cnt) < TIME_MIN_LEN)
                    time_field[int'(pay_cnt) - TIME_OFS] = b;
                pay_cnt = pay_cnt + 1'b1;
                fletcher(b);
                if (16'(pay_cnt) >= decl_len)
                    phase = PH_CK_A;
            end
            PH_CK_A: begin
                rx_ck_a = b;
                phase   = PH_CK_B;
            end
            PH_CK_B: begin
                sum_ok        = (rx_ck_a == sum_a) && (b == sum_b);
                r.event_kind  = EVT_FRAME;
                r.frame_class = held_cls;
                r.frame_id    = held_fid;
                r.item_length = decl_len[7:0];
                r.checksum_ok = sum_ok;
                if (sum_ok && held_cls == cfg.time_class && held_fid == cfg.time_id
                    && int'(decl_len) >= TIME_MIN_LEN) begin
                    yr  = {time_field[1], time_field[0]};
                    mon = time_field[2];
                    dd  = time_field[3];
                    if (time_field[7][VALID_UTC_BIT] && yr >= cfg.earliest_year
                        && mon >= 1 && mon <= 12 && dd >= 1 && dd <= 31) begin
                        r.time_accepted = 1'b1;
                        r.tm_year       = yr;
                        r.tm_month      = mon[3:0];
                        r.tm_day        = dd[4:0];
                        r.tm_hour       = time_field[4];
                        r.tm_minute     = time_field[5];
                        r.tm_second     = time_field[6];
                    end
                end
                drop_frame();
                return 1'b1;
            end
            default: drop_frame();
        endcase
        return 1'b0;
    endfunction

    task automatic compare_report(input t_result got, input t_result exp_rep);
        if (got.event_kind !== exp_rep.event_kind)
            report_mismatch("event_kind", 16'(got.event_kind), 16'(exp_rep.event_kind));
        if (got.frame_class !== exp_rep.frame_class)
            report_mismatch("frame_class", 16'(got.frame_class), 16'(exp_rep.frame_class));
        if (got.frame_id !== exp_rep.frame_id)
            report_mismatch("frame_id", 16'(got.frame_id), 16'(exp_rep.frame_id));
        if (got.item_length !== exp_rep.item_length)
            report_mismatch("item_length", 16'(got.item_length), 16'(exp_rep.item_length));
        if (got.checksum_ok !== exp_rep.checksum_ok)
            report_mismatch("checksum_ok", 16'(got.checksum_ok), 16'(exp_rep.checksum_ok));
        if (got.time_accepted !== exp_rep.time_accepted)
            report_mismatch("time_accepted", 16'(got.time_accepted),
                            16'(exp_rep.time_accepted));
        if (got.tm_year !== exp_rep.tm_year)
            report_mismatch("tm_year", got.tm_year, exp_rep.tm_year);
        if (got.tm_month !== exp_rep.tm_month)
            report_mismatch("tm_month", 16'(got.tm_month), 16'(exp_rep.tm_month));
        if (got.tm_day !== exp_rep.tm_day)
            report_mismatch("tm_day", 16'(got.tm_day), 16'(exp_rep.tm_day));
        if (got.tm_hour !== exp_rep.tm_hour)
            report_mismatch("tm_hour", 16'(got.tm_hour), 16'(exp_rep.tm_hour));
        if (got.tm_minute !== exp_rep.tm_minute)
            report_mismatch("tm_minute", 16'(got.tm_minute), 16'(exp_rep.tm_minute));
        if (got.tm_second !== exp_rep.tm_second)
            report_mismatch("tm_second", 16'(got.tm_second), 16'(exp_rep.tm_second));
    endtask

    // output side first: a report never belongs to the byte taken on the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_mirror();
            expected_reports.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("report with none expected, item_length",
                                    16'(i_result.item_length), 16'h0);
                end else begin
                    want = expected_reports.pop_front();
                    compare_report(i_result, want);
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_TIME_CLASS:    cfg.time_class    = i_cfg_wdata[7:0];
                    CFG_TIME_ID:       cfg.time_id       = i_cfg_wdata[7:0];
                    CFG_EARLIEST_YEAR: cfg.earliest_year = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (parse_byte(i_rx_byte, next_report))
                    expected_reports.push_back(next_report);
            end
        end
        pending_total = expected_reports.size();
    end

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ubxnmea_pkg::*;

    // sender and receiver each idle in roughly this many cycles out of a hundred
    localparam int IDLE_PCT      = 27;
    // receiver hold-off long enough to fill both internal registers and stall input
    localparam int HOLD_CYCLES   = 300;
    // leave a margin before touching the registers
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HDR_BYTES     = 4;
    // index 3 maps to no register; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            rx_byte;
    logic                  out_valid;
    logic                  out_ready;
    t_result               observed;

    logic                  ev_kind;
    logic [7:0]            f_class;
    logic [7:0]            f_id;
    logic [7:0]            it_len;
    logic                  ck_ok;
    logic                  t_acc;
    logic [15:0]           u_year;
    logic [3:0]            u_month;
    logic [4:0]            u_day;
    logic [7:0]            u_hour;
    logic [7:0]            u_minute;
    logic [7:0]            u_second;

    int                    pending;
    int                    fail_count;
    int                    bytes_sent;
    int                    cycle_count;

    // shared between stimulus and receiver
    bit                    quiet;
    bit                    hold_request;

    // our copy of what the time registers hold, for building time messages
    logic [7:0]            cur_cls;
    logic [7:0]            cur_fid;
    logic [15:0]           cur_year;

    assign observed = {ev_kind, f_class, f_id, it_len, ck_ok, t_acc,
                       u_year, u_month, u_day, u_hour, u_minute, u_second};

    ubx_nmea_stream_demux_parser uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_rx_byte       (rx_byte),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_event_kind    (ev_kind),
        .o_frame_class   (f_class),
        .o_frame_id      (f_id),
        .o_item_length   (it_len),
        .o_checksum_ok   (ck_ok),
        .o_time_accepted (t_acc),
        .o_tm_year       (u_year),
        .o_tm_month      (u_month),
        .o_tm_day        (u_day),
        .o_tm_hour       (u_hour),
        .o_tm_minute     (u_minute),
        .o_tm_second     (u_second)
    );

    ubx_nmea_report_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_rx_byte    (rx_byte),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_result     (observed),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** ubx_nmea_stream_demux_parser: FAILED **");
            $finish;
        end
    end

    // receiver: random back-pressure, or a long hold-off when asked for one
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // One byte transaction. Called at a falling edge, returns at the falling edge
    // after acceptance with valid still high, so a following byte needs no re-raise.
    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_chars(input int n);
        for (int k = 0; k < n; k++)
            send_byte(8'($urandom_range(int'(PRINT_LO), int'(PRINT_HI))));
    endtask

    task automatic send_line(input int n, input logic [7:0] term);
        send_chars(n);
        send_byte(term);
    endtask

    // mostly CR/LF; otherwise a control or high byte, which throws the line away unless it is CR or LF
    function automatic logic [7:0] pick_line_end();
        int          r;
        logic [7:0]  c;
        r = $urandom_range(99);
        if (r < 45)
            return ASCII_CR;
        if (r < 88)
            return ASCII_LF;
        if ($urandom_range(1))
            c = 8'($urandom_range(0, 31));
        else
            c = 8'($urandom_range(127, 255));
        if (c == SYNC_1)
            c = 8'h00;
        return c;
    endfunction

    // Full frame with Fletcher bytes. Payload is random; for length 20 and up the
    // time fields (year, month, day, flags) are overlaid. An over-long length sends
    // only the header, since the block drops the frame there.
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] fid,
                              input logic [15:0] len, input logic [15:0] yr,
                              input logic [7:0] mon, input logic [7:0] dd,
                              input logic [7:0] flg, input bit bad_sum);
        logic [7:0] body [$];
        logic [7:0] ca;
        logic [7:0] cb;
        bit         fits;
        fits = (int'(len) <= MAX_PAYLOAD);
        body.push_back(cls);
        body.push_back(fid);
        body.push_back(len[7:0]);
        body.push_back(len[15:8]);
        if (fits) begin
            for (int k = 0; k < int'(len); k++)
                body.push_back(8'($urandom));
            if (int'(len) >= TIME_MIN_LEN) begin
                body[HDR_BYTES + TIME_OFS]     = yr[7:0];
                body[HDR_BYTES + TIME_OFS + 1] = yr[15:8];
                body[HDR_BYTES + TIME_OFS + 2] = mon;
                body[HDR_BYTES + TIME_OFS + 3] = dd;
                body[HDR_BYTES + TIME_OFS + 7] = flg;
            end
        end
        ca = '0;
        cb = '0;
        for (int k = 0; k < body.size(); k++) begin
            ca = ca + body[k];
            cb = cb + ca;
        end
        if (bad_sum) begin
            if ($urandom_range(1))
                ca = ca ^ (8'h01 << $urandom_range(7));
            else
                cb = cb ^ (8'h01 << $urandom_range(7));
        end
        send_byte(SYNC_1);
        send_byte(SYNC_2);
        for (int k = 0; k < body.size(); k++)
            send_byte(body[k]);
        if (fits) begin
            send_byte(ca);
            send_byte(cb);
        end
    endtask

    // Time message aimed at the current registers, with dates near the edges
    task automatic send_time_frame();
        logic [7:0]  cls;
        logic [7:0]  fid;
        logic [7:0]  mon;
        logic [7:0]  dd;
        logic [7:0]  flg;
        logic [15:0] yr;
        logic [15:0] len;
        int          r;
        cls = cur_cls;
        fid = cur_fid;
        r   = $urandom_range(99);
        if (r < 8)
            cls = 8'($urandom);
        else if (r < 16)
            fid = 8'($urandom);
        case ($urandom_range(5))
            0: yr = cur_year;
            1: yr = cur_year - 16'd1;
            2: yr = cur_year + 16'($urandom_range(0, 50));
            3: yr = 16'hFFFF;
            4: yr = 16'($urandom);
            default: yr = cur_year + 16'd1;
        endcase
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(2))
                0: mon = 8'd0;
                1: mon = 8'd13;
                default: mon = 8'($urandom);
            endcase
        end else begin
            mon = 8'($urandom_range(1, 12));
        end
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(2))
                0: dd = 8'd0;
                1: dd = 8'd32;
                default: dd = 8'($urandom);
            endcase
        end else begin
            dd = 8'($urandom_range(1, 31));
        end
        flg = 8'($urandom);
        flg[VALID_UTC_BIT] = ($urandom_range(99) < 85);
        len = 16'($urandom_range(TIME_MIN_LEN, 28));
        if ($urandom_range(19) == 0)
            len = 16'(TIME_MIN_LEN - 1);
        send_frame(cls, fid, len, yr, mon, dd, flg, $urandom_range(99) < 10);
    endtask

    task automatic send_plain_frame();
        logic [15:0] len;
        int          r;
        r = $urandom_range(99);
        if (r < 10)
            len = 16'd0;
        else if (r < 85)
            len = 16'($urandom_range(1, 24));
        else if (r < 95)
            len = 16'($urandom_range(25, MAX_PAYLOAD));
        else
            len = 16'(MAX_PAYLOAD);
        send_frame(8'($urandom), 8'($urandom), len, 16'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), $urandom_range(99) < 15);
    endtask

    // random mix of traffic until the byte count reaches the target
    task automatic run_mixed(input int target);
        int          pick;
        logic [15:0] big_len;
        while (bytes_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 26) begin
                send_line($urandom_range(0, 12), pick_line_end());
            end else if (pick < 48) begin
                send_plain_frame();
            end else if (pick < 68) begin
                send_time_frame();
            end else if (pick < 75) begin
                if ($urandom_range(1))
                    big_len = 16'($urandom_range(MAX_PAYLOAD + 1, 255));
                else
                    big_len = 16'($urandom_range(256, 65535));
                send_frame(8'($urandom), 8'($urandom), big_len, 16'h0, 8'h0, 8'h0, 8'h0,
                           1'b0);
            end else if (pick < 84) begin
                // raw noise: any byte value, stray sync bytes included
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end else if (pick < 92) begin
                // line held open while a frame passes through
                send_chars($urandom_range(1, 5));
                send_time_frame();
                send_line($urandom_range(0, 5), ASCII_LF);
            end else if (pick < 96) begin
                send_line($urandom_range(100, LINE_CAPACITY + 2), pick_line_end());
            end else begin
                send_byte($urandom_range(1) ? ASCII_CR : ASCII_LF);
            end
        end
    endtask

    // Stop offering, wait for every expected report, then let the pipe drain
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // all registers plus the unused index, junk in the upper data bits
    task automatic write_config(input logic [7:0] cls, input logic [7:0] fid,
                                input logic [15:0] yr);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TIME_CLASS;
        cfg_wdata <= {8'($urandom), cls};
        @(negedge i_clk);
        cfg_index <= CFG_TIME_ID;
        cfg_wdata <= {8'($urandom), fid};
        @(negedge i_clk);
        cfg_index <= CFG_EARLIEST_YEAR;
        cfg_wdata <= yr;
        @(negedge i_clk);
        cfg_index <= CFG_UNUSED;
        cfg_wdata <= 16'($urandom);
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        cur_cls  = cls;
        cur_fid  = fid;
        cur_year = yr;
    endtask

    task automatic run_directed();
        // printable extremes as a two-character line, then an empty line end
        send_byte(PRINT_LO);
        send_byte(PRINT_HI);
        send_byte(ASCII_CR);
        send_byte(ASCII_LF);
        // non-printable bytes discard the held line, so the following ends report nothing
        send_chars(3);
        send_byte(8'h1F);
        send_byte(ASCII_LF);
        send_chars(2);
        send_byte(8'h7F);
        send_byte(ASCII_CR);
        send_chars(2);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(ASCII_LF);
        // accepted time messages at the edges of the date range
        send_frame(RST_TIME_CLASS, RST_TIME_ID, 16'(TIME_MIN_LEN), RST_EARLIEST_YEAR,
                   8'd1, 8'd31, 8'h04, 1'b0);
        send_frame(RST_TIME_CLASS, RST_TIME_ID, 16'd40, 16'hFFFF, 8'd12, 8'd1, 8'hFF,
                   1'b0);
        // rejected: too short, flag clear, year one short, month and day out of range
        send_frame(RST_TIME_CLASS, RST_TIME_ID, 16'(TIME_MIN_LEN - 1), RST_EARLIEST_YEAR,
                   8'd6, 8'd15, 8'h04, 1'b0);
        send_frame(RST_TIME_CLASS, RST_TIME_ID, 16'(TIME_MIN_LEN), RST_EARLIEST_YEAR,
                   8'd6, 8'd15, 8'hFB, 1'b0);
        send_frame(RST_TIME_CLASS, RST_TIME_ID, 16'(TIME_MIN_LEN),
                   RST_EARLIEST_YEAR - 16'd1, 8'd6, 8'd15, 8'h04, 1'b0);
        send_frame(RST_TIME_CLASS, RST_TIME_ID, 16'(TIME_MIN_LEN), RST_EARLIEST_YEAR,
                   8'd0, 8'd15, 8'h04, 1'b0);
        send_frame(RST_TIME_CLASS, RST_TIME_ID, 16'(TIME_MIN_LEN), RST_EARLIEST_YEAR,
                   8'd13, 8'd15, 8'h04, 1'b0);
        send_frame(RST_TIME_CLASS, RST_TIME_ID, 16'(TIME_MIN_LEN), RST_EARLIEST_YEAR,
                   8'd6, 8'd0, 8'h04, 1'b0);
        send_frame(RST_TIME_CLASS, RST_TIME_ID, 16'(TIME_MIN_LEN), RST_EARLIEST_YEAR,
                   8'd6, 8'd32, 8'h04, 1'b0);
        // good time message spoilt only by its checksum
        send_frame(RST_TIME_CLASS, RST_TIME_ID, 16'(TIME_MIN_LEN), RST_EARLIEST_YEAR,
                   8'd6, 8'd15, 8'h04, 1'b1);
        // zero length and maximum length
        send_frame(8'h00, 8'hFF, 16'd0, 16'h0, 8'h0, 8'h0, 8'h0, 1'b0);
        send_frame(8'hFF, 8'h00, 16'(MAX_PAYLOAD), 16'h0, 8'h0, 8'h0, 8'h0, 1'b0);
        // over-long frames vanish after the length; what follows is text again
        send_frame(8'h05, 8'h01, 16'(MAX_PAYLOAD + 1), 16'h0, 8'h0, 8'h0, 8'h0, 1'b0);
        send_line(2, ASCII_CR);
        send_frame(8'h05, 8'h01, 16'hFFFF, 16'h0, 8'h0, 8'h0, 8'h0, 1'b0);
        send_line(1, ASCII_LF);
        // bad second sync: the offending byte is swallowed, even when it is another B5
        send_byte(SYNC_1);
        send_byte(SYNC_1);
        send_line(1, ASCII_CR);
        send_byte(SYNC_1);
        send_byte(8'h00);
        // text count survives a frame passing through
        send_chars(4);
        send_frame(RST_TIME_CLASS, RST_TIME_ID, 16'(TIME_MIN_LEN), 16'd2030, 8'd3, 8'd9,
                   8'h04, 1'b0);
        send_chars(2);
        send_byte(ASCII_LF);
        // line capacity: one below fits, a full line overflows and is lost
        send_line(LINE_CAPACITY - 1, ASCII_LF);
        send_line(LINE_CAPACITY, ASCII_CR);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_TIME_CLASS;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        rx_byte      = '0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        bytes_sent   = 0;
        cycle_count  = 0;
        cur_cls      = RST_TIME_CLASS;
        cur_fid      = RST_TIME_ID;
        cur_year     = RST_EARLIEST_YEAR;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // registers at their reset values
        run_directed();
        run_mixed(bytes_sent + 150);
        settle();

        // everything zero: any year accepted, class and id zero
        write_config(8'h00, 8'h00, 16'h0000);
        // receiver goes away while short lines keep coming, so input must stall
        hold_request = 1'b1;
        repeat (45) send_line($urandom_range(1, 3), ASCII_CR);
        run_mixed(bytes_sent + 250);
        settle();

        // everything at maximum, first stretch with no idling on either side
        write_config(8'hFF, 8'hFF, 16'hFFFF);
        quiet = 1'b1;
        run_mixed(bytes_sent + 150);
        quiet = 1'b0;
        run_mixed(bytes_sent + 100);
        settle();

        write_config(8'($urandom), 8'($urandom), 16'($urandom_range(2000, 2060)));
        run_mixed(bytes_sent + 150);
        settle();

        write_config(RST_TIME_CLASS, RST_TIME_ID, RST_EARLIEST_YEAR);
        run_mixed(bytes_sent + 150);
        settle();

        if (fail_count == 0)
            $display("** ubx_nmea_stream_demux_parser: PASSED **");
        else
            $display("** ubx_nmea_stream_demux_parser: FAILED **");
        $finish;
    end

endmodule
